// ----- rtl/rsi_pkg.sv -----
// shared types and constants for the ray-sphere intersection pipeline
package rsi_pkg;

   localparam int COORD_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int DIAM_W   = 31;
   localparam int DIST_W   = 31;
   localparam int A_W      = 64;
   localparam int B_W      = 67;
   localparam int C4_W     = 69;
   localparam int MUL_W    = 72;
   localparam int LIMB_W   = 24;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int RAD_W    = 134;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int SREM_W   = ROOT_W + 3;
   localparam int N_W      = 68;
   localparam int DREM_W   = 96;
   localparam int MUL_LAT  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAM_X = 2'd0,
      CSR_CAM_Y = 2'd1,
      CSR_CAM_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ray_dir_x;
      logic signed [COORD_W-1:0] ray_dir_y;
      logic signed [COORD_W-1:0] ray_dir_z;
      logic signed [COORD_W-1:0] hit_origin_x;
      logic signed [COORD_W-1:0] hit_origin_y;
      logic signed [COORD_W-1:0] hit_origin_z;
      logic signed [COORD_W-1:0] sphere_center_x;
      logic signed [COORD_W-1:0] sphere_center_y;
      logic signed [COORD_W-1:0] sphere_center_z;
      logic [DIAM_W-1:0]         sphere_diameter;
      logic                      use_hitpoint;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] distance;
   } rsp_type;

   // sideband that rides along the square root stages
   typedef struct packed {
      logic                  valid;
      logic                  miss;
      logic [A_W-1:0]        a;
      logic signed [B_W-1:0] b;
   } sqrt_side_type;

   // sideband that rides along the divider stages
   typedef struct packed {
      logic           valid;
      logic           miss;
      logic           sat;
      logic [A_W-1:0] a;
   } div_side_type;

   // sideband that rides along the wide multipliers
   typedef struct packed {
      logic                  valid;
      logic                  azero;
      logic                  c4neg;
      logic [A_W-1:0]        a;
      logic signed [B_W-1:0] b;
   } mul_side_type;

endpackage

// ----- rtl/ray_sphere_intersect.sv -----
// top level of the ray-sphere intersection pipeline
//
// Tests one ray against one sphere per request and returns the nearest
// non-negative root of the ray-sphere quadratic as a Q15.16 distance, or a
// miss. A new request is taken every cycle while the pipeline is not stalled;
// from acceptance to result each one passes three input/product/sum stages, a
// three-stage wide multiplier, the discriminant stage, 67 square root stages
// (one root bit each), the root select stage, 32 divider stages (a saturation
// check, then one quotient bit each) and the output register. A stall on the
// result side freezes the whole pipeline, so req_stall follows rsp_stall while
// a result is held. The camera origin registers are written through the csr
// port, which is always ready; write them only while no request is in flight.
module ray_sphere_intersect (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rsi_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rsi_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rsi_pkg::COORD_W-1:0]         csr_data
);
   import rsi_pkg::*;

   logic adv;

   // camera origin registers
   logic signed [COORD_W-1:0] cam_x_ff, cam_y_ff, cam_z_ff;

   // stage 1: direction, origin minus centre, diameter
   logic                        v1_ff;
   logic signed [COORD_W-1:0]   d_ff  [3];
   logic signed [COORD_W:0]     oc_ff [3];
   logic [DIAM_W-1:0]           q_ff;
   logic signed [COORD_W:0]     oc_in [3];

   // stage 2: products
   logic                        v2_ff;
   logic signed [2*COORD_W-1:0] dd_ff  [3];
   logic signed [2*COORD_W:0]   doc_ff [3];
   logic signed [2*COORD_W+1:0] oo_ff  [3];
   logic [2*DIAM_W-1:0]         qq_ff;

   // stage 3: quadratic coefficients
   logic                        v3_ff;
   logic [A_W-1:0]              a_ff;
   logic signed [B_W-1:0]       b_ff;
   logic signed [C4_W-1:0]      c4_ff;
   logic [A_W-1:0]              a_in;
   logic signed [B_W-1:0]       b_in;
   logic signed [C4_W-1:0]      c4_in;

   // wide multiplier operands and sideband
   logic [MUL_W-1:0]            b_mag, c4_mag;
   logic [PROD_W-1:0]           bb_prod, ac_prod;
   mul_side_type                mside_ff [MUL_LAT];
   mul_side_type                mside_in;

   // discriminant stage
   sqrt_side_type               s4_side_ff;
   logic [RAD_W-1:0]            rad_ff;
   sqrt_side_type               s4_side_in;
   logic [RAD_W:0]              disc_in;

   // square root output
   sqrt_side_type               sq_side;
   logic [ROOT_W-1:0]           sq_root;

   // root select stage
   div_side_type                s5_side_ff;
   logic [N_W-1:0]              n_ff;
   div_side_type                s5_side_in;
   logic signed [N_W:0]         nb, n1, n2;
   logic [N_W-1:0]              n_in;

   // divider output and result register
   div_side_type                dv_side;
   logic [DIST_W-1:0]           dv_quot;
   logic                        out_valid_ff;
   rsp_type                     out_ff;
   rsp_type                     out_in;

   // whole pipeline advances unless a held result is stalled
   assign adv       = !(out_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // camera origin writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAM_X: cam_x_ff <= csr_data;
            CSR_CAM_Y: cam_y_ff <= csr_data;
            CSR_CAM_Z: cam_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // origin select and offset from the centre
   always_comb begin
      if (req_payload.use_hitpoint) begin
         oc_in[0] = (COORD_W+1)'(req_payload.hit_origin_x) - (COORD_W+1)'(req_payload.sphere_center_x);
         oc_in[1] = (COORD_W+1)'(req_payload.hit_origin_y) - (COORD_W+1)'(req_payload.sphere_center_y);
         oc_in[2] = (COORD_W+1)'(req_payload.hit_origin_z) - (COORD_W+1)'(req_payload.sphere_center_z);
      end else begin
         oc_in[0] = (COORD_W+1)'(cam_x_ff) - (COORD_W+1)'(req_payload.sphere_center_x);
         oc_in[1] = (COORD_W+1)'(cam_y_ff) - (COORD_W+1)'(req_payload.sphere_center_y);
         oc_in[2] = (COORD_W+1)'(cam_z_ff) - (COORD_W+1)'(req_payload.sphere_center_z);
      end
   end

   // valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // front stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0] <= req_payload.ray_dir_x;
         d_ff[1] <= req_payload.ray_dir_y;
         d_ff[2] <= req_payload.ray_dir_z;
         oc_ff   <= oc_in;
         q_ff    <= req_payload.sphere_diameter;
         for (int i = 0; i < 3; i++) begin
            dd_ff[i]  <= d_ff[i] * d_ff[i];
            doc_ff[i] <= d_ff[i] * oc_ff[i];
            oo_ff[i]  <= oc_ff[i] * oc_ff[i];
         end
         qq_ff <= q_ff * q_ff;
         a_ff  <= a_in;
         b_ff  <= b_in;
         c4_ff <= c4_in;
      end
   end

   // a = D.D, b = 2 D.OC, c4 = 4 OC.OC - q^2
   always_comb begin
      a_in  = A_W'(dd_ff[0]) + A_W'(dd_ff[1]) + A_W'(dd_ff[2]);
      b_in  = (B_W'(doc_ff[0]) + B_W'(doc_ff[1]) + B_W'(doc_ff[2])) <<< 1;
      c4_in = ((C4_W'(oo_ff[0]) + C4_W'(oo_ff[1]) + C4_W'(oo_ff[2])) <<< 2)
              - $signed(C4_W'(qq_ff));
   end

   // magnitudes into the wide multipliers
   assign b_mag  = MUL_W'(b_ff[B_W-1] ? -b_ff : b_ff);
   assign c4_mag = MUL_W'(c4_ff[C4_W-1] ? -c4_ff : c4_ff);

   rsi_mul72 u_mul_bb (
      .clock (clock),
      .adv   (adv),
      .op_a  (b_mag),
      .op_b  (b_mag),
      .prod  (bb_prod)
   );

   rsi_mul72 u_mul_ac (
      .clock (clock),
      .adv   (adv),
      .op_a  (MUL_W'(a_ff)),
      .op_b  (c4_mag),
      .prod  (ac_prod)
   );

   // sideband alongside the multipliers
   always_comb begin
      mside_in.valid = v3_ff;
      mside_in.azero = (a_ff == '0);
      mside_in.c4neg = c4_ff[C4_W-1];
      mside_in.a     = a_ff;
      mside_in.b     = b_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MUL_LAT; i++) begin
         if (reset) begin
            mside_ff[i] <= '0;
         end else if (adv) begin
            mside_ff[i] <= (i == 0) ? mside_in : mside_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // discriminant b^2 - a c4 and its sign
   always_comb begin
      if (mside_ff[MUL_LAT-1].c4neg) begin
         disc_in = (RAD_W+1)'(bb_prod) + (RAD_W+1)'(ac_prod);
      end else begin
         disc_in = (RAD_W+1)'(bb_prod) - (RAD_W+1)'(ac_prod);
      end
      s4_side_in.valid = mside_ff[MUL_LAT-1].valid;
      s4_side_in.miss  = mside_ff[MUL_LAT-1].azero || disc_in[RAD_W];
      s4_side_in.a     = mside_ff[MUL_LAT-1].a;
      s4_side_in.b     = mside_ff[MUL_LAT-1].b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_side_ff <= '0;
      end else if (adv) begin
         s4_side_ff <= s4_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff <= disc_in[RAD_W-1:0];
      end
   end

   rsi_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_side  (s4_side_ff),
      .in_rad   (rad_ff),
      .out_side (sq_side),
      .out_root (sq_root)
   );

   // nearer root first, then the far one, else miss
   always_comb begin
      nb = -((N_W+1)'(sq_side.b));
      n1 = nb - $signed((N_W+1)'(sq_root));
      n2 = nb + $signed((N_W+1)'(sq_root));
      s5_side_in.valid = sq_side.valid;
      s5_side_in.sat   = 1'b0;
      s5_side_in.a     = sq_side.a;
      if (!n1[N_W]) begin
         n_in            = n1[N_W-1:0];
         s5_side_in.miss = sq_side.miss;
      end else begin
         n_in            = n2[N_W-1:0];
         s5_side_in.miss = sq_side.miss || n2[N_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_side_ff <= '0;
      end else if (adv) begin
         s5_side_ff <= s5_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff <= n_in;
      end
   end

   rsi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_side  (s5_side_ff),
      .in_num   (n_ff),
      .out_side (dv_side),
      .out_quot (dv_quot)
   );

   // result register
   always_comb begin
      out_in.hit = !dv_side.miss;
      if (dv_side.miss) begin
         out_in.distance = '0;
      end else if (dv_side.sat) begin
         out_in.distance = DIST_MAX;
      end else begin
         out_in.distance = dv_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef NO_ASSERTIONS
   // input side is held back only by a stalled result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall without a stalled result");

   // a miss never carries a distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.hit) |-> (rsp_payload.distance == '0))
      else $error("miss result with nonzero distance");

   // a frozen pipeline keeps its front stage
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(v1_ff))
      else $error("front stage moved during stall");
`endif

endmodule

// ----- rtl/rsi_mul72.sv -----
// three-stage unsigned 72x72 multiplier built from 24-bit limb products
module rsi_mul72 (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [rsi_pkg::MUL_W-1:0]   op_a,
   input  logic [rsi_pkg::MUL_W-1:0]   op_b,
   output logic [rsi_pkg::PROD_W-1:0]  prod
);
   import rsi_pkg::*;

   localparam int NLIMB = MUL_W / LIMB_W;
   localparam int ROW_W = LIMB_W * (NLIMB + 1);

   logic [2*LIMB_W-1:0] pp_ff [NLIMB][NLIMB];
   logic [ROW_W-1:0]    row_ff [NLIMB];
   logic [ROW_W-1:0]    row_in [NLIMB];
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;

   // limb partial products
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NLIMB; i++) begin
            for (int j = 0; j < NLIMB; j++) begin
               pp_ff[i][j] <= op_a[i*LIMB_W +: LIMB_W] * op_b[j*LIMB_W +: LIMB_W];
            end
         end
      end
   end

   // one row per limb of op_a
   always_comb begin
      for (int i = 0; i < NLIMB; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NLIMB; j++) begin
            row_in[i] = row_in[i] + (ROW_W'(pp_ff[i][j]) << (j * LIMB_W));
         end
      end
   end

   // rows summed into the full product
   always_comb begin
      prod_in = '0;
      for (int i = 0; i < NLIMB; i++) begin
         prod_in = prod_in + (PROD_W'(row_ff[i]) << (i * LIMB_W));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         row_ff  <= row_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/rsi_sqrt.sv -----
// pipelined integer square root, one root bit per stage
module rsi_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  rsi_pkg::sqrt_side_type      in_side,
   input  logic [rsi_pkg::RAD_W-1:0]   in_rad,
   output rsi_pkg::sqrt_side_type      out_side,
   output logic [rsi_pkg::ROOT_W-1:0]  out_root
);
   import rsi_pkg::*;

   sqrt_side_type       side_ff [ROOT_W];
   logic [RAD_W-1:0]    rad_ff  [ROOT_W];
   logic [SREM_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];

   sqrt_side_type       side_in [ROOT_W];
   logic [RAD_W-1:0]    rad_in  [ROOT_W];
   logic [SREM_W-1:0]   rem_in  [ROOT_W];
   logic [ROOT_W-1:0]   root_in [ROOT_W];

   // each stage brings down two radicand bits and tries the next root bit
   always_comb begin
      logic [RAD_W-1:0]  rad_p;
      logic [SREM_W-1:0] rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [SREM_W-1:0] rem_w;
      logic [SREM_W-1:0] trial;
      for (int i = 0; i < ROOT_W; i++) begin
         side_in[i] = (i == 0) ? in_side : side_ff[(i == 0) ? 0 : i - 1];
         rad_p  = (i == 0) ? in_rad : rad_ff[(i == 0) ? 0 : i - 1];
         rem_p  = (i == 0) ? '0 : rem_ff[(i == 0) ? 0 : i - 1];
         root_p = (i == 0) ? '0 : root_ff[(i == 0) ? 0 : i - 1];
         rem_w  = {rem_p[SREM_W-3:0], rad_p[RAD_W-1 -: 2]};
         trial  = {root_p, 2'b01};
         rad_in[i] = rad_p << 2;
         if (rem_w >= trial) begin
            rem_in[i]  = rem_w - trial;
            root_in[i] = {root_p[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = rem_w;
            root_in[i] = {root_p[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROOT_W; i++) begin
         if (reset) begin
            side_ff[i] <= '0;
         end else if (adv) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_side = side_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];

endmodule

// ----- rtl/rsi_div.sv -----
// saturation check and pipelined restoring divide, one quotient bit per stage
module rsi_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  rsi_pkg::div_side_type       in_side,
   input  logic [rsi_pkg::N_W-1:0]     in_num,
   output rsi_pkg::div_side_type       out_side,
   output logic [rsi_pkg::DIST_W-1:0]  out_quot
);
   import rsi_pkg::*;

   localparam int CMP_W = A_W + 2 * FRAC_W;

   div_side_type        head_side_ff;
   logic [DREM_W-1:0]   head_rem_ff;

   div_side_type        side_ff [DIST_W];
   logic [DREM_W-1:0]   rem_ff  [DIST_W];
   logic [DIST_W-1:0]   quot_ff [DIST_W];

   div_side_type        side_in [DIST_W];
   logic [DREM_W-1:0]   rem_in  [DIST_W];
   logic [DIST_W-1:0]   quot_in [DIST_W];

   div_side_type        head_side_in;

   // quotient reaches 2^31 exactly when num >= a * 2^16
   always_comb begin
      head_side_in = in_side;
      head_side_in.sat = CMP_W'({in_num, {FRAC_W{1'b0}}}) >= {in_side.a, {2*FRAC_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_side_ff <= '0;
      end else if (adv) begin
         head_side_ff <= head_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         head_rem_ff <= DREM_W'({in_num, {FRAC_W{1'b0}}});
      end
   end

   // stage i decides quotient bit DIST_W-1-i against 2a shifted up
   always_comb begin
      div_side_type      side_p;
      logic [DREM_W-1:0] rem_p;
      logic [DIST_W-1:0] quot_p;
      logic [DREM_W:0]   trial;
      for (int i = 0; i < DIST_W; i++) begin
         side_p = (i == 0) ? head_side_ff : side_ff[(i == 0) ? 0 : i - 1];
         rem_p  = (i == 0) ? head_rem_ff : rem_ff[(i == 0) ? 0 : i - 1];
         quot_p = (i == 0) ? '0 : quot_ff[(i == 0) ? 0 : i - 1];
         trial  = {1'b0, rem_p} - ((DREM_W+1)'({side_p.a, 1'b0}) << (DIST_W - 1 - i));
         side_in[i] = side_p;
         quot_in[i] = quot_p;
         if (!trial[DREM_W]) begin
            rem_in[i] = trial[DREM_W-1:0];
            quot_in[i][DIST_W-1-i] = 1'b1;
         end else begin
            rem_in[i] = rem_p;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIST_W; i++) begin
         if (reset) begin
            side_ff[i] <= '0;
         end else if (adv) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign out_side = side_ff[DIST_W-1];
   assign out_quot = quot_ff[DIST_W-1];

endmodule
